/* src/qvr_pkg.sv */
// Package for the quaternion vector rotation block: widths, payload structs
// and the queue and pipeline sizes. No dependencies; all other files import it.
`default_nettype none

package qvr_pkg;

    // Field widths.
    localparam int CW = 16;          // vector and quaternion component width
    localparam int QF = 14;          // quaternion fraction bits

    // Datapath widths, all derived from the field widths.
    localparam int PROD_W    = 2 * CW;          // quaternion product
    localparam int DCM_W     = PROD_W + 2;      // matrix entry, sum of two times two
    localparam int TERM_W    = DCM_W + CW;      // matrix entry times vector component
    localparam int ACC_W     = TERM_W + 2;      // three-term sum plus rounding
    localparam int RND_SHIFT = 2 * QF;          // fraction bits of the sum
    localparam int SH_W      = ACC_W - RND_SHIFT;

    // Queue and pipeline sizes.
    localparam int MID_DEPTH   = 4;
    localparam int MID_AW      = $clog2(MID_DEPTH);
    localparam int MID_CW      = MID_AW + 1;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = OUT_AW + 1;
    localparam int PIPE_STAGES = 4;

    typedef logic signed [CW-1:0]     comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DCM_W-1:0]  dcm_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // Half of one output LSB at the accumulator scale.
    localparam acc_t ROUND_HALF = acc_t'(1) <<< (RND_SHIFT - 1);

    typedef struct packed {
        logic  action;
        comp_t quat_w;
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
        comp_t in_x;
        comp_t in_y;
        comp_t in_z;
    } qvr_item_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        logic  saturated;
    } qvr_result_t;

    // Classified work item passed from the front part to the back part.
    typedef struct packed {
        logic  transpose;
        comp_t qw;
        comp_t qx;
        comp_t qy;
        comp_t qz;
        comp_t vx;
        comp_t vy;
        comp_t vz;
    } qvr_job_t;

endpackage

`default_nettype wire

/* src/qvr_front.sv */
// Front part of the quaternion vector rotation: accepts items, decodes the
// rotation direction and holds classified jobs in a short queue. Uses qvr_pkg.
`default_nettype none

module qvr_front
    import qvr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire qvr_item_t item,
    output logic           job_valid,
    input  wire logic      job_ready,
    output qvr_job_t       job
);

    qvr_job_t           slot_reg [MID_DEPTH];
    logic [MID_AW-1:0]  wr_ptr_reg;
    logic [MID_AW-1:0]  wr_ptr_next;
    logic [MID_AW-1:0]  rd_ptr_reg;
    logic [MID_AW-1:0]  rd_ptr_next;
    logic [MID_CW-1:0]  count_reg;
    logic [MID_CW-1:0]  count_next;
    logic               wr_en;
    logic               rd_en;
    qvr_job_t           classified;

    // The single action bit selects the direction.
    always_comb
    begin
        classified.transpose = item.action;
        classified.qw        = item.quat_w;
        classified.qx        = item.quat_x;
        classified.qy        = item.quat_y;
        classified.qz        = item.quat_z;
        classified.vx        = item.in_x;
        classified.vy        = item.in_y;
        classified.vz        = item.in_z;
    end

    assign full      = (count_reg == MID_CW'(MID_DEPTH));
    assign wr_en     = push && !full;
    assign job_valid = (count_reg != '0);
    assign rd_en     = job_valid && job_ready;
    assign job       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + MID_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + MID_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + MID_CW'(wr_en) - MID_CW'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/qvr_back.sv */
// Back part of the quaternion vector rotation: four-stage arithmetic pipeline
// with a credit-checked result queue. Uses qvr_pkg.
`default_nettype none

module qvr_back
    import qvr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    output logic          job_ready,
    input  wire qvr_job_t job,
    output logic          empty,
    input  wire logic     pop,
    output qvr_result_t   result
);

    // Issue control and valid bits of the pipeline stages.
    logic [OUT_CW-1:0]      reserved_reg;
    logic [OUT_CW-1:0]      reserved_next;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic                   issue;
    logic                   pop_en;

    // Stage one: quaternion products.
    prod_t p_reg [10];
    comp_t v1_reg [3];
    logic  tr1_reg;

    // Stage two: selected matrix, row-major, transposed when asked.
    dcm_t  dcm   [9];
    dcm_t  m_next [9];
    dcm_t  m_reg  [9];
    comp_t v2_reg [3];

    // Stage three: matrix entry times vector component.
    term_t t_reg [9];

    // Stage four: rounded row sums.
    acc_t  acc_reg [3];

    // Final rounding shift and saturation.
    logic [SH_W-1:0] hi [3];
    logic [2:0]      clip;
    qvr_result_t     finished;

    // Result queue.
    qvr_result_t       rq_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] rq_wr_reg;
    logic [OUT_AW-1:0] rq_rd_reg;
    logic [OUT_CW-1:0] rq_cnt_reg;
    logic [OUT_CW-1:0] rq_cnt_next;
    logic              rq_wr;

    // A job is issued only while the result queue has room for every item
    // already in flight, so the pipeline itself never stalls.
    assign job_ready = (reserved_reg < OUT_CW'(OUT_DEPTH));
    assign issue     = job_valid && job_ready;
    assign empty     = (rq_cnt_reg == '0);
    assign pop_en    = pop && !empty;
    assign rq_wr     = vld_reg[PIPE_STAGES-1];
    assign result    = rq_reg[rq_rd_reg];

    always_comb
    begin
        reserved_next = reserved_reg + OUT_CW'(issue) - OUT_CW'(pop_en);
        vld_next      = {vld_reg[PIPE_STAGES-2:0], issue};
        rq_cnt_next   = rq_cnt_reg + OUT_CW'(rq_wr) - OUT_CW'(pop_en);
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= prod_t'(job.qw) * prod_t'(job.qw);
        p_reg[1] <= prod_t'(job.qx) * prod_t'(job.qx);
        p_reg[2] <= prod_t'(job.qy) * prod_t'(job.qy);
        p_reg[3] <= prod_t'(job.qz) * prod_t'(job.qz);
        p_reg[4] <= prod_t'(job.qw) * prod_t'(job.qx);
        p_reg[5] <= prod_t'(job.qw) * prod_t'(job.qy);
        p_reg[6] <= prod_t'(job.qw) * prod_t'(job.qz);
        p_reg[7] <= prod_t'(job.qx) * prod_t'(job.qy);
        p_reg[8] <= prod_t'(job.qx) * prod_t'(job.qz);
        p_reg[9] <= prod_t'(job.qy) * prod_t'(job.qz);
        v1_reg[0] <= job.vx;
        v1_reg[1] <= job.vy;
        v1_reg[2] <= job.vz;
        tr1_reg   <= job.transpose;
    end

    // Product order: ww, xx, yy, zz, wx, wy, wz, xy, xz, yz.
    always_comb
    begin
        dcm[0] = dcm_t'(p_reg[0]) + dcm_t'(p_reg[1]) - dcm_t'(p_reg[2]) - dcm_t'(p_reg[3]);
        dcm[1] = (dcm_t'(p_reg[7]) + dcm_t'(p_reg[6])) <<< 1;
        dcm[2] = (dcm_t'(p_reg[8]) - dcm_t'(p_reg[5])) <<< 1;
        dcm[3] = (dcm_t'(p_reg[7]) - dcm_t'(p_reg[6])) <<< 1;
        dcm[4] = dcm_t'(p_reg[0]) - dcm_t'(p_reg[1]) + dcm_t'(p_reg[2]) - dcm_t'(p_reg[3]);
        dcm[5] = (dcm_t'(p_reg[9]) + dcm_t'(p_reg[4])) <<< 1;
        dcm[6] = (dcm_t'(p_reg[8]) + dcm_t'(p_reg[5])) <<< 1;
        dcm[7] = (dcm_t'(p_reg[9]) - dcm_t'(p_reg[4])) <<< 1;
        dcm[8] = dcm_t'(p_reg[0]) - dcm_t'(p_reg[1]) - dcm_t'(p_reg[2]) + dcm_t'(p_reg[3]);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m_next[3*r+c] = tr1_reg ? dcm[3*c+r] : dcm[3*r+c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_reg[k] <= m_next[k];
        end
        for (int c = 0; c < 3; c++)
        begin
            v2_reg[c] <= v1_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t_reg[3*r+c] <= term_t'(m_reg[3*r+c]) * term_t'(v2_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_reg[r] <= acc_t'(t_reg[3*r]) + acc_t'(t_reg[3*r+1])
                        + acc_t'(t_reg[3*r+2]) + ROUND_HALF;
        end
    end

    // Dropping the fraction bits is the arithmetic right shift; a component
    // fits when all bits from its sign bit upward agree.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            hi[r]   = acc_reg[r][ACC_W-1:RND_SHIFT];
            clip[r] = !((&hi[r][SH_W-1:CW-1]) || !(|hi[r][SH_W-1:CW-1]));
        end
        finished.out_x = clip[0] ? {hi[0][SH_W-1], {(CW-1){!hi[0][SH_W-1]}}} : hi[0][CW-1:0];
        finished.out_y = clip[1] ? {hi[1][SH_W-1], {(CW-1){!hi[1][SH_W-1]}}} : hi[1][CW-1:0];
        finished.out_z = clip[2] ? {hi[2][SH_W-1], {(CW-1){!hi[2][SH_W-1]}}} : hi[2][CW-1:0];
        finished.saturated = |clip;
    end

    always_ff @(posedge clk)
    begin
        if (rq_wr)
        begin
            rq_reg[rq_wr_reg] <= finished;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            vld_reg      <= '0;
            rq_wr_reg    <= '0;
            rq_rd_reg    <= '0;
            rq_cnt_reg   <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            vld_reg      <= vld_next;
            rq_wr_reg    <= rq_wr ? rq_wr_reg + OUT_AW'(1) : rq_wr_reg;
            rq_rd_reg    <= pop_en ? rq_rd_reg + OUT_AW'(1) : rq_rd_reg;
            rq_cnt_reg   <= rq_cnt_next;
        end
    end

    // Every reserved slot is either in the pipeline or in the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(reserved_reg) == int'(rq_cnt_reg) + $countones(vld_reg))
        else $error("qvr_back: credit count out of step with items in flight");

    // The credit check keeps the result queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rq_wr |-> (rq_cnt_reg < OUT_CW'(OUT_DEPTH)))
        else $error("qvr_back: result written into a full queue");

    // A finished result is visible on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rq_wr |=> !empty)
        else $error("qvr_back: written result not visible");

endmodule

`default_nettype wire

/* src/quaternion_vector_rotation.sv */
// Top level of the quaternion vector rotation block: joins the front part,
// which queues classified items, to the back part, which computes them. Uses qvr_pkg.
//
// Each transfer in carries a Q1.14 quaternion, a 16-bit vector and a direction
// bit; each transfer out carries the vector rotated by the quaternion's direction
// cosine matrix (direction bit low) or by its transpose (direction bit high),
// rounded to nearest with ties toward plus infinity, saturated to 16 bits, and
// a flag that is set when any component was clipped. The quaternion is used as
// given, without normalization. Both sides behave as queues: an item is taken
// when push is high and full is low, and the oldest result is shown while empty
// is low and leaves when pop is high. The block takes one item per clock cycle
// and gives one result per cycle for as long as results are popped. A taken
// item passes through the four-entry input queue and four pipeline stages
// (quaternion products, matrix entries, matrix-vector products, row sums with
// rounding), with the final shift and saturation done as the result enters
// the eight-entry output queue. Results leave in the order the items came in.
// When pop stays low, items already in flight still land in the output queue,
// and the block stops issuing once that queue and the pipeline together hold
// eight results; the input queue then fills and full rises.
`default_nettype none

module quaternion_vector_rotation
    import qvr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire qvr_item_t   item,
    output logic             empty,
    input  wire logic        pop,
    output qvr_result_t      result
);

    // Jobs handed from the front queue to the arithmetic pipeline.
    logic     job_valid;
    logic     job_ready;
    qvr_job_t job;

    qvr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    qvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
